// ===== rtl/xml_item_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer modules.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef XML_ITEM_TOKENIZER_DEFINES_SVH
`define XML_ITEM_TOKENIZER_DEFINES_SVH

// General property check.
`define XIT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define XIT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/xit_pkg.sv =====
`timescale 1ns / 1ps

package xit_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_WAIT       = 4'd1,
      MODE_TYPE       = 4'd2,
      MODE_NAME       = 4'd3,
      MODE_PI         = 4'd4,
      MODE_WS_FOUND   = 4'd5,
      MODE_TYPE_FOUND = 4'd6,
      MODE_NAME_FOUND = 4'd7,
      MODE_PI_FOUND   = 4'd8,
      MODE_ERROR      = 4'd9
   } mode_type;

   localparam logic [1:0] FUNC_CHAR  = 2'd0;
   localparam logic [1:0] FUNC_CMD   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] ACT_ITEM = 2'd0;
   localparam logic [1:0] ACT_NAME = 2'd1;
   localparam logic [1:0] ACT_PI   = 2'd2;

   localparam logic [1:0] OPT_NONE    = 2'd0;
   localparam logic [1:0] OPT_SYNC    = 2'd1;
   localparam logic [1:0] OPT_SKIP_WS = 2'd2;

   localparam logic [2:0] ST_MORE = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_ERR  = 3'd2;
   localparam logic [2:0] ST_VAL  = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_REJ  = 3'd5;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_WS      = 3'd1;
   localparam logic [2:0] KIND_PI      = 3'd2;
   localparam logic [2:0] KIND_DOCTYPE = 3'd3;
   localparam logic [2:0] KIND_COMMENT = 3'd4;
   localparam logic [2:0] KIND_ELEMENT = 3'd5;

   localparam logic [20:0] CH_LT    = 21'h3C;
   localparam logic [20:0] CH_GT    = 21'h3E;
   localparam logic [20:0] CH_QUEST = 21'h3F;
   localparam logic [20:0] CH_BANG  = 21'h21;

   // Lengths of the spellings that follow '<' for comments and doctypes.
   localparam logic [3:0] CMT_LEN = 4'd3;
   localparam logic [3:0] DOC_LEN = 4'd8;

   // Response queue: four entries, a request is processed only while two are free.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam logic [2:0]  ROOM_LIMIT  = 3'(QUEUE_DEPTH - 2);

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  kind;
      logic [20:0] code_point;
      logic        last;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  option;
      logic        held_valid;
      logic [20:0] held_cp;
      logic [3:0]  prefix_idx;
      logic [1:0]  cands;
      logic        q_pend;
      logic        name_started;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_IDLE,
      option:       2'd0,
      held_valid:   1'b0,
      held_cp:      21'd0,
      prefix_idx:   4'd0,
      cands:        2'b11,
      q_pend:       1'b0,
      name_started: 1'b0
   };

   // Up to two responses produced by one processed request.
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

   typedef struct packed {
      state_type  st;
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } step_type;

   function automatic logic is_ws(logic [20:0] c);
      return c inside {21'h20, 21'h09, 21'h0D, 21'h0A};
   endfunction

   function automatic logic is_xml_char(logic [20:0] c);
      return c inside {21'h09, 21'h0A, 21'h0D, [21'h20 : 21'hD7FF],
                       [21'hE000 : 21'hFFFD], [21'h10000 : 21'h10FFFF]};
   endfunction

   function automatic logic is_name_start(logic [20:0] c);
      return c inside {21'h3A, [21'h41 : 21'h5A], 21'h5F, [21'h61 : 21'h7A],
                       [21'hC0 : 21'hD6], [21'hD8 : 21'hF6], [21'hF8 : 21'h2FF],
                       [21'h370 : 21'h37D], [21'h37F : 21'h1FFF],
                       [21'h200C : 21'h200D], [21'h2070 : 21'h218F],
                       [21'h2C00 : 21'h2FEF], [21'h3001 : 21'hD7FF],
                       [21'hF900 : 21'hFDCF], [21'hFDF0 : 21'hFFFD],
                       [21'h10000 : 21'hEFFFF]};
   endfunction

   function automatic logic is_name_char(logic [20:0] c);
      return is_name_start(c) ||
             (c inside {21'h2D, 21'h2E, [21'h30 : 21'h39], 21'hB7,
                        [21'h300 : 21'h36F], [21'h203F : 21'h2040]});
   endfunction

   // Spelling of "!--".
   function automatic logic [20:0] cmt_char(logic [3:0] idx);
      logic [20:0] r;
      case (idx)
         4'd0:    r = CH_BANG;
         4'd1:    r = 21'h2D;
         4'd2:    r = 21'h2D;
         default: r = 21'h0;
      endcase
      return r;
   endfunction

   // Spelling of "!DOCTYPE".
   function automatic logic [20:0] doc_char(logic [3:0] idx);
      logic [20:0] r;
      case (idx)
         4'd0:    r = CH_BANG;
         4'd1:    r = 21'h44;
         4'd2:    r = 21'h4F;
         4'd3:    r = 21'h43;
         4'd4:    r = 21'h54;
         4'd5:    r = 21'h59;
         4'd6:    r = 21'h50;
         4'd7:    r = 21'h45;
         default: r = 21'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/xml_item_tokenizer.sv =====
`timescale 1ns / 1ps
// A request is registered in the input register, and its responses are registered in the
// response queue whose head drives the output. One request per cycle is taken while the
// queue has two free entries, so the four-entry queue absorbs a second response.
// Reset is synchronous and active high; it empties the input register and the
// response queue and returns the parser to idle.

module xml_item_tokenizer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [20:0] req_character,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_option,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_item_kind,
   output logic [20:0] rsp_code_point,
   output logic        rsp_last
);

   // Input register. A request sits here while the engine works on it, and stays
   // longer when the response queue lacks room for two responses.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  in_func_ff;
   logic [20:0] in_char_ff;
   logic [1:0]  in_action_ff;
   logic [1:0]  in_option_ff;

   logic              req_accept;
   logic              step_en;
   logic              room;
   logic              pop;
   logic [2:0]        fifo_count;
   xit_pkg::push_type push;
   xit_pkg::rsp_type  head;

   // The engine may produce two responses for one request, so it only steps
   // while the queue has two free entries. The input register refills in the
   // same cycle that its request is consumed.
   assign room       = fifo_count <= xit_pkg::ROOM_LIMIT;
   assign step_en    = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff   <= req_func;
         in_char_ff   <= req_character;
         in_action_ff <= req_action;
         in_option_ff <= req_option;
      end
   end

   // Parser state and the single-pass classification of one request.
   xit_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .func      (in_func_ff),
      .character (in_char_ff),
      .action    (in_action_ff),
      .option    (in_option_ff),
      .push      (push)
   );

   // Response queue; its head drives the response channel directly.
   xit_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (fifo_count)
   );

   assign rsp_valid      = fifo_count != 3'd0;
   assign pop            = rsp_valid && !rsp_stall;
   assign rsp_status     = head.status;
   assign rsp_item_kind  = head.kind;
   assign rsp_code_point = head.code_point;
   assign rsp_last       = head.last;

endmodule

// ===== rtl/xit_engine.sv =====
`timescale 1ns / 1ps
`include "xml_item_tokenizer_defines.svh"

module xit_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [1:0]        func,
   input  logic [20:0]       character,
   input  logic [1:0]        action,
   input  logic [1:0]        option,
   output xit_pkg::push_type push
);

   xit_pkg::state_type state_ff;
   xit_pkg::state_type state_in;
   xit_pkg::state_type cmd_state;
   xit_pkg::step_type  base;
   xit_pkg::step_type  acc;
   xit_pkg::step_type  res;
   xit_pkg::mode_type  cmd_mode;
   logic               cmd_ok;

   // Append one response to a step.
   function automatic xit_pkg::step_type add_res(xit_pkg::step_type i, logic [2:0] status,
                                                 logic [2:0] kind, logic [20:0] cp);
      xit_pkg::step_type o;
      xit_pkg::rsp_type  e;
      o            = i;
      e.status     = status;
      e.kind       = kind;
      e.code_point = cp;
      e.last       = 1'b0;
      if (i.cnt == 2'd0) begin
         o.r0 = e;
      end else begin
         o.r1 = e;
      end
      o.cnt = i.cnt + 2'd1;
      return o;
   endfunction

   // Process one character in the parse state carried by the step.
   function automatic xit_pkg::step_type char_step(xit_pkg::step_type i, logic [20:0] c);
      xit_pkg::step_type  o;
      xit_pkg::state_type s;
      logic [1:0]         keep;
      logic [3:0]         nidx;
      o    = i;
      s    = i.st;
      keep = 2'b00;
      nidx = s.prefix_idx + 4'd1;
      case (s.mode)
         xit_pkg::MODE_WAIT: begin
            if (c == xit_pkg::CH_LT) begin
               o.st.mode       = xit_pkg::MODE_TYPE;
               o.st.prefix_idx = 4'd0;
               o.st.cands      = 2'b11;
            end else if (s.option != xit_pkg::OPT_SYNC) begin
               if (xit_pkg::is_ws(c)) begin
                  if (s.option != xit_pkg::OPT_SKIP_WS) begin
                     o.st.mode = xit_pkg::MODE_WS_FOUND;
                     o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_WS, c);
                  end
               end else begin
                  o.st.mode = xit_pkg::MODE_ERROR;
                  o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
               end
            end
         end
         xit_pkg::MODE_TYPE: begin
            if (s.prefix_idx == 4'd0) begin
               if (c == xit_pkg::CH_QUEST) begin
                  o.st.mode = xit_pkg::MODE_TYPE_FOUND;
                  o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_PI, xit_pkg::CH_QUEST);
               end else if (c == xit_pkg::CH_BANG) begin
                  o.st.prefix_idx = 4'd1;
                  o.st.cands      = 2'b11;
               end else if (xit_pkg::is_name_start(c)) begin
                  o.st.held_valid = 1'b1;
                  o.st.held_cp    = c;
                  o.st.mode       = xit_pkg::MODE_TYPE_FOUND;
                  o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_ELEMENT, 21'd0);
               end else begin
                  o.st.mode = xit_pkg::MODE_ERROR;
                  o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
               end
            end else begin
               // Comment and doctype spellings are tracked as separate candidates.
               keep[0] = s.cands[0] && (s.prefix_idx < xit_pkg::CMT_LEN) &&
                         (c == xit_pkg::cmt_char(s.prefix_idx));
               keep[1] = s.cands[1] && (s.prefix_idx < xit_pkg::DOC_LEN) &&
                         (c == xit_pkg::doc_char(s.prefix_idx));
               if (keep == 2'b00) begin
                  o.st.mode = xit_pkg::MODE_ERROR;
                  o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
               end else begin
                  o.st.cands      = keep;
                  o.st.prefix_idx = nidx;
                  if (keep[0] && (nidx == xit_pkg::CMT_LEN)) begin
                     o.st.mode = xit_pkg::MODE_TYPE_FOUND;
                     o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_COMMENT, 21'd0);
                  end else if (keep[1] && (nidx == xit_pkg::DOC_LEN)) begin
                     o.st.mode = xit_pkg::MODE_TYPE_FOUND;
                     o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_DOCTYPE, 21'd0);
                  end
               end
            end
         end
         xit_pkg::MODE_NAME: begin
            if (!s.name_started) begin
               if (xit_pkg::is_name_start(c)) begin
                  o.st.name_started = 1'b1;
                  o = add_res(o, xit_pkg::ST_VAL, xit_pkg::KIND_NONE, c);
               end else if (!((s.option == xit_pkg::OPT_SKIP_WS) && xit_pkg::is_ws(c))) begin
                  o.st.mode = xit_pkg::MODE_ERROR;
                  o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
               end
            end else if (xit_pkg::is_name_char(c)) begin
               o = add_res(o, xit_pkg::ST_VAL, xit_pkg::KIND_NONE, c);
            end else begin
               o.st.held_valid = 1'b1;
               o.st.held_cp    = c;
               o.st.mode       = xit_pkg::MODE_NAME_FOUND;
               o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_NONE, c);
            end
         end
         xit_pkg::MODE_PI: begin
            o.st.q_pend = 1'b0;
            if (!xit_pkg::is_xml_char(c)) begin
               o.st.mode = xit_pkg::MODE_ERROR;
               o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
            end else if (s.q_pend && (c == xit_pkg::CH_GT)) begin
               o.st.mode = xit_pkg::MODE_PI_FOUND;
               o = add_res(o, xit_pkg::ST_DONE, xit_pkg::KIND_NONE, 21'd0);
            end else begin
               // A held '?' that is not followed by '>' is part of the value.
               if (s.q_pend) begin
                  o = add_res(o, xit_pkg::ST_VAL, xit_pkg::KIND_NONE, xit_pkg::CH_QUEST);
               end
               if (c == xit_pkg::CH_QUEST) begin
                  o.st.q_pend = 1'b1;
               end else begin
                  o = add_res(o, xit_pkg::ST_VAL, xit_pkg::KIND_NONE, c);
               end
            end
         end
         default: begin
            o.st.mode = xit_pkg::MODE_ERROR;
            o = add_res(o, xit_pkg::ST_ERR, xit_pkg::KIND_NONE, c);
         end
      endcase
      return o;
   endfunction

   always_comb begin
      cmd_ok   = 1'b0;
      cmd_mode = xit_pkg::MODE_ERROR;
      case (action)
         xit_pkg::ACT_ITEM: begin
            cmd_ok = (state_ff.mode inside {xit_pkg::MODE_IDLE, xit_pkg::MODE_WS_FOUND,
                                            xit_pkg::MODE_PI_FOUND}) &&
                     (option inside {xit_pkg::OPT_NONE, xit_pkg::OPT_SYNC,
                                     xit_pkg::OPT_SKIP_WS});
            cmd_mode = xit_pkg::MODE_WAIT;
         end
         xit_pkg::ACT_NAME: begin
            cmd_ok = (state_ff.mode == xit_pkg::MODE_TYPE_FOUND) &&
                     (option inside {xit_pkg::OPT_NONE, xit_pkg::OPT_SKIP_WS});
            cmd_mode = xit_pkg::MODE_NAME;
         end
         xit_pkg::ACT_PI: begin
            cmd_ok = (state_ff.mode == xit_pkg::MODE_NAME_FOUND) &&
                     (option inside {xit_pkg::OPT_NONE, xit_pkg::OPT_SKIP_WS});
            cmd_mode = xit_pkg::MODE_PI;
         end
         default: begin
            cmd_ok   = 1'b0;
            cmd_mode = xit_pkg::MODE_ERROR;
         end
      endcase

      cmd_state              = state_ff;
      cmd_state.mode         = cmd_mode;
      cmd_state.option       = option;
      cmd_state.prefix_idx   = 4'd0;
      cmd_state.cands        = 2'b11;
      cmd_state.q_pend       = 1'b0;
      cmd_state.name_started = 1'b0;
      cmd_state.held_valid   = 1'b0;
      cmd_state.held_cp      = 21'd0;

      base.st  = state_ff;
      base.cnt = 2'd0;
      base.r0  = '0;
      base.r1  = '0;

      acc    = base;
      acc.st = cmd_state;
      acc    = add_res(acc, xit_pkg::ST_ACC, xit_pkg::KIND_NONE, 21'd0);

      case (func)
         xit_pkg::FUNC_CHAR: begin
            res = char_step(base, character);
            if (res.cnt == 2'd0) begin
               res = add_res(res, xit_pkg::ST_MORE, xit_pkg::KIND_NONE, 21'd0);
            end
         end
         xit_pkg::FUNC_CMD: begin
            if (!cmd_ok) begin
               res = add_res(base, xit_pkg::ST_REJ, xit_pkg::KIND_NONE, 21'd0);
            end else if (state_ff.held_valid) begin
               // The held character is replayed at once in the new mode.
               res = char_step(acc, state_ff.held_cp);
            end else begin
               res = acc;
            end
         end
         xit_pkg::FUNC_CLEAR: begin
            res    = base;
            res.st = xit_pkg::STATE_RESET;
            res    = add_res(res, xit_pkg::ST_ACC, xit_pkg::KIND_NONE, 21'd0);
         end
         default: begin
            res = add_res(base, xit_pkg::ST_REJ, xit_pkg::KIND_NONE, 21'd0);
         end
      endcase

      if (res.cnt == 2'd2) begin
         res.r1.last = 1'b1;
      end else begin
         res.r0.last = 1'b1;
      end

      state_in = res.st;
      push.cnt = step_en ? res.cnt : 2'd0;
      push.r0  = res.r0;
      push.r1  = res.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xit_pkg::STATE_RESET;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   `XIT_ASSERT(a_error_sticky, ((state_ff.mode == xit_pkg::MODE_ERROR) && step_en && (func != xit_pkg::FUNC_CLEAR)) |=> (state_ff.mode == xit_pkg::MODE_ERROR), "error mode left without a clear")
   `XIT_ASSERT_IMPL(a_no_held_in_read, (state_ff.mode == xit_pkg::MODE_WAIT) || (state_ff.mode == xit_pkg::MODE_TYPE) || (state_ff.mode == xit_pkg::MODE_NAME) || (state_ff.mode == xit_pkg::MODE_PI), !state_ff.held_valid, "held character left unconsumed in a reading mode")
   `XIT_ASSERT_IMPL(a_step_has_rsp, step_en, push.cnt != 2'd0, "processed request produced no response")

endmodule

// ===== rtl/xit_rsp_fifo.sv =====
`timescale 1ns / 1ps
`include "xml_item_tokenizer_defines.svh"

module xit_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  xit_pkg::push_type push,
   input  logic              pop,
   output xit_pkg::rsp_type  head,
   output logic [2:0]        count
);

   xit_pkg::rsp_type              queue_ff [xit_pkg::QUEUE_DEPTH];
   logic [xit_pkg::QUEUE_AW-1:0]  wr_ptr_ff;
   logic [xit_pkg::QUEUE_AW-1:0]  wr_ptr_in;
   logic [xit_pkg::QUEUE_AW-1:0]  wr_next;
   logic [xit_pkg::QUEUE_AW-1:0]  rd_ptr_ff;
   logic [xit_pkg::QUEUE_AW-1:0]  rd_ptr_in;
   logic [2:0]                    count_ff;
   logic [2:0]                    count_in;

   always_comb begin
      wr_next   = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + push.cnt[xit_pkg::QUEUE_AW-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.cnt} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         queue_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = queue_ff[rd_ptr_ff];
   assign count = count_ff;

   `XIT_ASSERT_IMPL(a_push_room, push.cnt != 2'd0, count_ff <= xit_pkg::ROOM_LIMIT, "responses pushed without two free entries")
   `XIT_ASSERT(a_count_bound, count_ff <= 3'(xit_pkg::QUEUE_DEPTH), "response queue overflow")
   `XIT_ASSERT(a_ptr_track, wr_ptr_ff == (rd_ptr_ff + count_ff[xit_pkg::QUEUE_AW-1:0]), "queue pointers disagree with fill count")

endmodule

// ===== dv/xit_stream_check.sv =====
`timescale 1ns / 1ps

module xit_stream_check
   import xit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [20:0] req_character,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_option,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [2:0]  rsp_item_kind,
   input  logic [20:0] rsp_code_point,
   input  logic        rsp_last,

   output int unsigned failures,
   output int unsigned outstanding
);

   localparam string COMMENT_OPEN = "!--";
   localparam string DOCTYPE_OPEN = "!DOCTYPE";
   localparam int unsigned MAX_PER_REQUEST = 3;

   // Shadow copy of the parser state.
   mode_type    mode;
   logic [1:0]  saved_opt;
   logic        held_v;
   logic [20:0] held_c;
   logic [3:0]  prefix_pos;
   logic [1:0]  prefix_live;
   logic        quest_pend;
   logic        name_open;

   rsp_type     step_out[$];
   rsp_type     awaited[$];

   function automatic bit is_blank(logic [20:0] c);
      return c == 21'h20 || c == 21'h09 || c == 21'h0D || c == 21'h0A;
   endfunction

   function automatic bit is_legal(logic [20:0] c);
      return c == 21'h09 || c == 21'h0A || c == 21'h0D ||
             (c >= 21'h20 && c <= 21'hD7FF) || (c >= 21'hE000 && c <= 21'hFFFD) ||
             (c >= 21'h10000 && c <= 21'h10FFFF);
   endfunction

   function automatic bit is_name_head(logic [20:0] c);
      return c == 21'h3A || c == 21'h5F ||
             (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
             (c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hF6) ||
             (c >= 21'hF8 && c <= 21'h2FF) || (c >= 21'h370 && c <= 21'h37D) ||
             (c >= 21'h37F && c <= 21'h1FFF) || (c >= 21'h200C && c <= 21'h200D) ||
             (c >= 21'h2070 && c <= 21'h218F) || (c >= 21'h2C00 && c <= 21'h2FEF) ||
             (c >= 21'h3001 && c <= 21'hD7FF) || (c >= 21'hF900 && c <= 21'hFDCF) ||
             (c >= 21'hFDF0 && c <= 21'hFFFD) || (c >= 21'h10000 && c <= 21'hEFFFF);
   endfunction

   function automatic bit is_name_tail(logic [20:0] c);
      return is_name_head(c) || c == 21'h2D || c == 21'h2E || c == 21'hB7 ||
             (c >= 21'h30 && c <= 21'h39) || (c >= 21'h300 && c <= 21'h36F) ||
             (c >= 21'h203F && c <= 21'h2040);
   endfunction

   function automatic logic [20:0] spelled(string s, logic [3:0] pos);
      return {13'd0, s[pos]};
   endfunction

   function automatic void clear_parser();
      mode        = MODE_IDLE;
      saved_opt   = OPT_NONE;
      held_v      = 1'b0;
      held_c      = '0;
      prefix_pos  = '0;
      prefix_live = 2'b11;
      quest_pend  = 1'b0;
      name_open   = 1'b0;
   endfunction

   function automatic void add_result(logic [2:0] st, logic [2:0] kind, logic [20:0] cp);
      rsp_type r;
      if (step_out.size() < MAX_PER_REQUEST) begin
         r.status     = st;
         r.kind       = kind;
         r.code_point = cp;
         r.last       = 1'b0;
         step_out.push_back(r);
      end
   endfunction

   function automatic void enter_error(logic [20:0] c);
      mode = MODE_ERROR;
      add_result(ST_ERR, KIND_NONE, c);
   endfunction

   function automatic void item_char(logic [20:0] c);
      if (c == CH_LT) begin
         mode        = MODE_TYPE;
         prefix_pos  = '0;
         prefix_live = 2'b11;
      end else if (saved_opt == OPT_SYNC) begin
         // Synchronizing: everything up to the next '<' is dropped.
      end else if (is_blank(c)) begin
         if (saved_opt != OPT_SKIP_WS) begin
            mode = MODE_WS_FOUND;
            add_result(ST_DONE, KIND_WS, c);
         end
      end else begin
         enter_error(c);
      end
   endfunction

   function automatic void type_char(logic [20:0] c);
      logic [1:0] keep;
      keep = 2'b00;
      if (prefix_pos == 4'd0) begin
         if (c == CH_QUEST) begin
            mode = MODE_TYPE_FOUND;
            add_result(ST_DONE, KIND_PI, CH_QUEST);
         end else if (c == CH_BANG) begin
            prefix_pos  = 4'd1;
            prefix_live = 2'b11;
         end else if (is_name_head(c)) begin
            // The first name character stays held for the read name command.
            held_v = 1'b1;
            held_c = c;
            mode   = MODE_TYPE_FOUND;
            add_result(ST_DONE, KIND_ELEMENT, '0);
         end else begin
            enter_error(c);
         end
         return;
      end
      if (prefix_live[0] && prefix_pos < CMT_LEN && c == spelled(COMMENT_OPEN, prefix_pos))
         keep[0] = 1'b1;
      if (prefix_live[1] && prefix_pos < DOC_LEN && c == spelled(DOCTYPE_OPEN, prefix_pos))
         keep[1] = 1'b1;
      if (keep == 2'b00) begin
         enter_error(c);
         return;
      end
      prefix_live = keep;
      prefix_pos  = prefix_pos + 4'd1;
      if (keep[0] && prefix_pos == CMT_LEN) begin
         mode = MODE_TYPE_FOUND;
         add_result(ST_DONE, KIND_COMMENT, '0);
      end else if (keep[1] && prefix_pos == DOC_LEN) begin
         mode = MODE_TYPE_FOUND;
         add_result(ST_DONE, KIND_DOCTYPE, '0);
      end
   endfunction

   function automatic void name_char(logic [20:0] c);
      if (!name_open) begin
         if (is_name_head(c)) begin
            name_open = 1'b1;
            add_result(ST_VAL, KIND_NONE, c);
         end else if (!(saved_opt == OPT_SKIP_WS && is_blank(c))) begin
            enter_error(c);
         end
      end else if (is_name_tail(c)) begin
         add_result(ST_VAL, KIND_NONE, c);
      end else begin
         held_v = 1'b1;
         held_c = c;
         mode   = MODE_NAME_FOUND;
         add_result(ST_DONE, KIND_NONE, c);
      end
   endfunction

   function automatic void value_char(logic [20:0] c);
      if (!is_legal(c)) begin
         quest_pend = 1'b0;
         enter_error(c);
         return;
      end
      if (quest_pend) begin
         quest_pend = 1'b0;
         if (c == CH_GT) begin
            mode = MODE_PI_FOUND;
            add_result(ST_DONE, KIND_NONE, '0);
            return;
         end
         add_result(ST_VAL, KIND_NONE, CH_QUEST);
      end
      if (c == CH_QUEST)
         quest_pend = 1'b1;
      else
         add_result(ST_VAL, KIND_NONE, c);
   endfunction

   function automatic void parse_char(logic [20:0] c);
      case (mode)
         MODE_WAIT: item_char(c);
         MODE_TYPE: type_char(c);
         MODE_NAME: name_char(c);
         MODE_PI:   value_char(c);
         default:   enter_error(c);
      endcase
   endfunction

   function automatic void run_command(logic [1:0] act, logic [1:0] opt);
      mode_type    next_mode;
      bit          ok;
      logic [20:0] c;
      ok        = 1'b0;
      next_mode = MODE_ERROR;
      case (act)
         ACT_ITEM: begin
            ok = (mode == MODE_IDLE || mode == MODE_WS_FOUND || mode == MODE_PI_FOUND) &&
                 (opt == OPT_NONE || opt == OPT_SYNC || opt == OPT_SKIP_WS);
            next_mode = MODE_WAIT;
         end
         ACT_NAME: begin
            ok = mode == MODE_TYPE_FOUND && (opt == OPT_NONE || opt == OPT_SKIP_WS);
            next_mode = MODE_NAME;
         end
         ACT_PI: begin
            ok = mode == MODE_NAME_FOUND && (opt == OPT_NONE || opt == OPT_SKIP_WS);
            next_mode = MODE_PI;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         add_result(ST_REJ, KIND_NONE, '0);
         return;
      end
      mode        = next_mode;
      saved_opt   = opt;
      prefix_pos  = '0;
      prefix_live = 2'b11;
      quest_pend  = 1'b0;
      name_open   = 1'b0;
      add_result(ST_ACC, KIND_NONE, '0);
      if (held_v) begin
         c      = held_c;
         held_v = 1'b0;
         held_c = '0;
         parse_char(c);
      end
   endfunction

   function automatic void predict_responses(logic [1:0] func, logic [20:0] c,
                                             logic [1:0] act, logic [1:0] opt);
      rsp_type r;
      step_out.delete();
      case (func)
         FUNC_CHAR: begin
            parse_char(c);
            if (step_out.size() == 0)
               add_result(ST_MORE, KIND_NONE, '0);
         end
         FUNC_CMD: run_command(act, opt);
         FUNC_CLEAR: begin
            clear_parser();
            add_result(ST_ACC, KIND_NONE, '0);
         end
         default: add_result(ST_REJ, KIND_NONE, '0);
      endcase
      r      = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
      foreach (step_out[i])
         awaited.push_back(step_out[i]);
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] tokenizer response error: %s", $time, what);
      failures++;
   endtask

   task automatic check_field(string field, logic [20:0] got, logic [20:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
   endtask

   initial begin
      failures    = 0;
      outstanding = 0;
      clear_parser();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parser();
         awaited.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_responses(req_func, req_character, req_action, req_option);
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("response with status %0d while none was due",
                                         rsp_status));
            end else begin
               want = awaited.pop_front();
               check_field("status", 21'(rsp_status), 21'(want.status));
               check_field("item kind", 21'(rsp_item_kind), 21'(want.kind));
               check_field("code point", rsp_code_point, want.code_point);
               check_field("last flag", 21'(rsp_last), 21'(want.last));
            end
         end
      end
      outstanding = awaited.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the markup tokenizer. The checker instantiated next
// to the block predicts every response and compares it; this module only feeds
// requests, applies back-pressure on the response side and decides the outcome.
module tb_top;
   import xit_pkg::*;

   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned RANDOM_ITEMS = 380;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;

   // Codes that the block must refuse: the spare function, action and option.
   localparam logic [1:0]  FUNC_SPARE = 2'd3;
   localparam logic [1:0]  ACT_SPARE  = 2'd3;
   localparam logic [1:0]  OPT_SPARE  = 2'd3;

   localparam logic [20:0] CP_TOP      = 21'h1FFFFF;
   localparam logic [20:0] CP_BEYOND   = 21'h110000;
   localparam logic [20:0] CH_DASH     = 21'h2D;
   localparam logic [20:0] CH_SPACE    = 21'h20;
   localparam string       DOCTYPE_TAIL = "DOCTYPE";

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [20:0] req_character;
   logic [1:0]  req_action;
   logic [1:0]  req_option;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_item_kind;
   logic [20:0] rsp_code_point;
   logic        rsp_last;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned requests_sent;
   int unsigned cycle_count;

   // When set, the matching side runs without any idle cycles for a while.
   bit send_calm;
   bit take_calm;
   // Set when a well-formed sequence had a character swapped for a random one.
   bit spoiled;

   xml_item_tokenizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_character  (req_character),
      .req_action     (req_action),
      .req_option     (req_option),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_code_point (rsp_code_point),
      .rsp_last       (rsp_last)
   );

   xit_stream_check stream_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_character  (req_character),
      .req_action     (req_action),
      .req_option     (req_option),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_code_point (rsp_code_point),
      .rsp_last       (rsp_last),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Character pickers. They aim at the classes the tokenizer tells apart;
   // a few of the ranges straddle a class border on purpose.
   // ------------------------------------------------------------------

   function automatic logic [20:0] pick_space();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return 21'h09;
         2:       return 21'h0D;
         default: return 21'h0A;
      endcase
   endfunction

   function automatic logic [20:0] pick_name_head();
      case ($urandom_range(0, 9))
         0, 1, 2: return 21'(21'h61 + $urandom_range(0, 25));
         3:       return 21'(21'h41 + $urandom_range(0, 25));
         4:       return $urandom_range(0, 1) ? 21'h3A : 21'h5F;
         5:       return 21'($urandom_range(21'hC0, 21'h2FF));
         6:       return 21'($urandom_range(21'h370, 21'h1FFF));
         7:       return 21'($urandom_range(21'h3001, 21'hD7FF));
         8:       return 21'($urandom_range(21'hF900, 21'hFFFD));
         default: return 21'($urandom_range(21'h10000, 21'hEFFFF));
      endcase
   endfunction

   function automatic logic [20:0] pick_name_tail();
      case ($urandom_range(0, 6))
         0, 1, 2: return pick_name_head();
         3:       return 21'(21'h30 + $urandom_range(0, 9));
         4:       return $urandom_range(0, 1) ? CH_DASH : 21'h2E;
         5:       return $urandom_range(0, 1) ? 21'hB7 : 21'($urandom_range(21'h300, 21'h36F));
         default: return 21'($urandom_range(21'h203F, 21'h2040));
      endcase
   endfunction

   // Text of a processing instruction value: legal characters only.
   function automatic logic [20:0] pick_text();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 21'($urandom_range(21'h20, 21'h7E));
         4:          return pick_space();
         5:          return 21'($urandom_range(21'hA0, 21'hD7FF));
         6:          return 21'($urandom_range(21'hE000, 21'hFFFD));
         default:    return 21'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
   endfunction

   // Anything at all, with the edges of the legal ranges drawn often.
   function automatic logic [20:0] pick_any();
      case ($urandom_range(0, 4))
         0: return 21'($urandom_range(0, CP_TOP));
         1: begin
            case ($urandom_range(0, 8))
               0:       return 21'h0;
               1:       return 21'h1F;
               2:       return 21'hD800;
               3:       return 21'hDFFF;
               4:       return 21'hFFFE;
               5:       return 21'hFFFF;
               6:       return 21'h10FFFF;
               7:       return CP_BEYOND;
               default: return CP_TOP;
            endcase
         end
         2:       return pick_text();
         3:       return pick_name_head();
         default: return 21'($urandom_range(0, 21'h7F));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver. It is always entered at a falling edge and returns at
   // the falling edge after the request was taken, so a back-to-back request
   // keeps valid high without lowering it in between.
   // ------------------------------------------------------------------

   task automatic send_request(logic [1:0] func, logic [20:0] ch,
                               logic [1:0] act, logic [1:0] opt);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func      = func;
      req_character = ch;
      req_action    = act;
      req_option    = opt;
      req_valid     = 1'b1;
      // Taken at the first rising edge that sees the stall low.
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      requests_sent++;
   endtask

   // The unused fields of each request carry random bits, so every bit of
   // every field toggles over the run.
   task automatic send_char(logic [20:0] ch);
      send_request(FUNC_CHAR, ch, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
   endtask

   task automatic send_cmd(logic [1:0] act, logic [1:0] opt);
      send_request(FUNC_CMD, 21'($urandom_range(0, CP_TOP)), act, opt);
   endtask

   task automatic send_clear();
      send_request(FUNC_CLEAR, 21'($urandom_range(0, CP_TOP)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
   endtask

   // A character of a well-formed sequence; now and then it gets corrupted.
   task automatic send_text(logic [20:0] ch);
      if ($urandom_range(0, 39) == 0) begin
         ch      = pick_any();
         spoiled = 1'b1;
      end
      send_char(ch);
   endtask

   // Read name command and the name itself. When the item was an element the
   // first name character is already held inside the block.
   task automatic name_part(bit head_held);
      logic [1:0]  opt;
      int unsigned len;
      opt = $urandom_range(0, 1) ? OPT_NONE : OPT_SKIP_WS;
      len = $urandom_range(0, 6);
      send_cmd(ACT_NAME, opt);
      if (!head_held) begin
         if (opt == OPT_SKIP_WS)
            repeat ($urandom_range(0, 2)) send_text(pick_space());
         send_text(pick_name_head());
      end
      repeat (len) send_text(pick_name_tail());
      // The character that ends the name is held for the next command.
      case ($urandom_range(0, 3))
         0:       send_text(pick_space());
         1:       send_text(CH_QUEST);
         2:       send_text(CH_GT);
         default: send_text(pick_any());
      endcase
   endtask

   // Read PI value command and a value with stray question marks in it,
   // closed by '?>'.
   task automatic value_part();
      send_cmd(ACT_PI, $urandom_range(0, 1) ? OPT_NONE : OPT_SKIP_WS);
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 5) == 0)
            send_text(CH_QUEST);
         send_text(pick_text());
      end
      send_text(CH_QUEST);
      send_text(CH_GT);
   endtask

   // One markup item from the read item command onward: whitespace, PI,
   // comment, doctype or element.
   task automatic markup_sequence();
      logic [1:0]  opt;
      int unsigned kind;
      bit          clean_end;
      spoiled = 1'b0;
      if ($urandom_range(0, 9) == 0)
         send_calm = !send_calm;
      opt  = 2'($urandom_range(0, 2));
      kind = $urandom_range(0, 4);
      send_cmd(ACT_ITEM, opt);
      // Material in front of the item that the chosen option lets through.
      repeat ($urandom_range(0, 2)) begin
         if (opt == OPT_SYNC)
            send_text(21'($urandom_range(21'h20, 21'h3B)));
         else if (opt == OPT_SKIP_WS)
            send_text(pick_space());
      end
      clean_end = (kind == 1) || (kind == 0 && opt == OPT_NONE);
      if (kind == 0 && opt == OPT_NONE) begin
         send_text(pick_space());
      end else begin
         send_text(CH_LT);
         case (kind)
            1: begin
               send_text(CH_QUEST);
               name_part(1'b0);
               value_part();
            end
            2: begin
               send_text(CH_BANG);
               send_text(CH_DASH);
               send_text(CH_DASH);
               if ($urandom_range(0, 1))
                  name_part(1'b0);
            end
            3: begin
               send_text(CH_BANG);
               for (int i = 0; i < DOCTYPE_TAIL.len(); i++)
                  send_text(21'(DOCTYPE_TAIL[i]));
               name_part(1'b0);
               if ($urandom_range(0, 1))
                  value_part();
            end
            default: begin
               send_text(pick_name_head());
               name_part(1'b1);
               if ($urandom_range(0, 1))
                  value_part();
            end
         endcase
      end
      // Only a finished whitespace or PI item accepts the next read item
      // command directly; everything else is cleared, and so is a clean
      // ending from time to time.
      if (spoiled || !clean_end || $urandom_range(0, 7) == 0)
         send_clear();
   endtask

   // Unstructured requests: any function, any character, any command code.
   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         send_request(2'($urandom_range(0, 3)), pick_any(),
                      2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 1))
         send_clear();
   endtask

   // ------------------------------------------------------------------
   // Response side: a random number of stalled cycles before each response,
   // with calm stretches where every response is taken at once.
   // ------------------------------------------------------------------
   initial begin
      int unsigned gap;
      rsp_stall = 1'b0;
      take_calm = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = take_calm ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         if ($urandom_range(0, 39) == 0)
            take_calm = !take_calm;
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit");
      $display("xml_item_tokenizer: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int unsigned stop_at;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_CHAR;
      req_character = '0;
      req_action    = ACT_ITEM;
      req_option    = OPT_NONE;
      requests_sent = 0;
      send_calm     = 1'b0;
      spoiled       = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Refused codes first: the spare function, a spare
      // action and option, and a read name command while idle.
      send_request(FUNC_SPARE, CP_TOP, ACT_SPARE, OPT_SPARE);
      send_cmd(ACT_SPARE, OPT_SPARE);
      send_cmd(ACT_NAME, OPT_NONE);
      // A character while idle, here the largest code point, is an error.
      // The error sticks: commands are refused, characters fail again.
      send_char(CP_TOP);
      send_cmd(ACT_ITEM, OPT_NONE);
      send_char(21'h0);
      send_clear();
      send_cmd(ACT_ITEM, OPT_SPARE);
      // "<!D" leaves only the doctype spelling alive, so a dash must fail
      // even though it would have continued a comment opening.
      send_cmd(ACT_ITEM, OPT_NONE);
      send_char(CH_LT);
      send_char(CH_BANG);
      send_char(21'h44);
      send_char(CH_DASH);
      send_clear();
      // Leading blank skipped, then a PI whose target name ends on '?'.
      send_cmd(ACT_ITEM, OPT_SKIP_WS);
      send_char(CH_SPACE);
      send_char(CH_LT);
      send_char(CH_QUEST);
      send_cmd(ACT_NAME, OPT_SKIP_WS);
      send_char(21'h78);
      send_char(CH_QUEST);
      // The held '?' becomes a pending question mark in the value; the next
      // character flushes it. A later pending '?' is dropped by a character
      // beyond the Unicode range, which is an error.
      send_cmd(ACT_PI, OPT_NONE);
      send_char(21'h61);
      send_char(CH_QUEST);
      send_char(CP_BEYOND);
      send_clear();

      // Random part: mostly well-formed items with random content.
      stop_at = requests_sent + RANDOM_ITEMS;
      while (requests_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0)
            noise_burst();
         else
            markup_sequence();
      end
      req_valid = 1'b0;

      // Every request gives at least one response, so once nothing is owed
      // only a short settling time is left.
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0)
         $display("xml_item_tokenizer: match");
      else
         $display("xml_item_tokenizer: mismatch");
      $finish;
   end

endmodule
